// ===== sv/lfu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LFU cache package
// Shared types and constants of the LFU key-value store.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned CNT_W       = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic signed [31:0] READ_MISS = -32'sd1;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic               func;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } rsp_t;

  typedef struct packed {
    logic [31:0]      key;
    logic [31:0]      data;
    logic [CNT_W-1:0] count;
    logic [31:0]      stamp;
  } entry_t;

endpackage
`default_nettype wire

// ===== sv/lfu_cache_replacement.sv =====
// An accepted request is scanned against the entry memory, which is read through
// its single read port, one entry a cycle; the write state then waits while the
// output register holds an unaccepted result, and the result is registered there.
// No new request is taken until the block is back in idle.
// Reset clears the valid bits, the fill count and the stamp clock at once;
// the entry memory itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LFU cache with LRU tie-break
// Key-value store whose entries live in a synchronous memory; each request
// scans the memory, then writes at most one chosen entry.
// ----------------------------------------------------------------------------
module lfu_cache_replacement #(
  parameter int unsigned ENTRIES = lfu_pkg::ENTRIES_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [lfu_pkg::CAP_W-1:0] cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire lfu_pkg::req_t           in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output lfu_pkg::rsp_t                out_data_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned SW = $clog2(ENTRIES + 1);
  localparam int unsigned FW = $clog2(ENTRIES + 1);
  localparam int unsigned CW = (FW > lfu_pkg::CAP_W) ? FW : lfu_pkg::CAP_W;

  lfu_pkg::entry_t mem [ENTRIES];
  lfu_pkg::entry_t rd_q;
  lfu_pkg::entry_t wr_ent;
  logic [IW-1:0]   rd_addr, wr_addr;
  logic            rd_en, we;

  lfu_pkg::state_e state_q, state_d;
  lfu_pkg::req_t   req_q;
  logic [SW-1:0]   cnt_q, cnt_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [FW-1:0]   filled_q, filled_d;
  logic [31:0]     clk_q, clk_d;
  logic [lfu_pkg::CAP_W-1:0] cap_q;

  logic            hit_q, hit_d;
  logic [IW-1:0]   hit_idx_q, hit_idx_d;
  lfu_pkg::entry_t hit_ent_q, hit_ent_d;
  logic            vic_q, vic_d;
  logic [IW-1:0]   vic_idx_q, vic_idx_d;
  logic [31:0]     vic_key_q, vic_key_d;
  logic [lfu_pkg::CNT_W-1:0] vic_cnt_q, vic_cnt_d;
  logic [31:0]     vic_age_q, vic_age_d;
  logic            free_q, free_d;
  logic [IW-1:0]   free_idx_q, free_idx_d;

  logic            out_valid_q, out_valid_d;
  lfu_pkg::rsp_t   out_q, out_d;

  logic [IW-1:0]   chk_idx;
  logic [31:0]     age;
  logic            full, evict;
  logic [IW-1:0]   dst;
  logic [lfu_pkg::CNT_W-1:0] bumped;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == lfu_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Synchronous entry memory, one read and one write port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_ent;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfu_pkg::ST_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      filled_q    <= '0;
      clk_q       <= '0;
      cap_q       <= lfu_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      filled_q    <= filled_d;
      clk_q       <= clk_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_ent_q  <= hit_ent_d;
    vic_q      <= vic_d;
    vic_idx_q  <= vic_idx_d;
    vic_key_q  <= vic_key_d;
    vic_cnt_q  <= vic_cnt_d;
    vic_age_q  <= vic_age_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    out_q      <= out_d;
  end

  assign chk_idx = IW'(cnt_q - SW'(1));
  assign age     = clk_q - rd_q.stamp;
  assign full    = (CW'(filled_q) >= CW'(cap_q)) || (filled_q == FW'(ENTRIES));
  assign evict   = full && vic_q;
  assign dst     = (evict && (!free_q || vic_idx_q < free_idx_q)) ? vic_idx_q : free_idx_q;
  assign bumped  = (hit_ent_q.count == lfu_pkg::COUNT_MAX) ? hit_ent_q.count
                                                           : hit_ent_q.count + 1'b1;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    filled_d    = filled_q;
    clk_d       = clk_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_ent_d   = hit_ent_q;
    vic_d       = vic_q;
    vic_idx_d   = vic_idx_q;
    vic_key_d   = vic_key_q;
    vic_cnt_d   = vic_cnt_q;
    vic_age_d   = vic_age_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    rd_en       = 1'b0;
    rd_addr     = cnt_q[IW-1:0];
    we          = 1'b0;
    wr_addr     = hit_idx_q;
    wr_ent      = hit_ent_q;

    case (state_q)
      lfu_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = lfu_pkg::ST_SCAN;
          cnt_d   = '0;
          hit_d   = 1'b0;
          vic_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      lfu_pkg::ST_SCAN: begin
        if (cnt_q < SW'(ENTRIES)) begin
          rd_en   = 1'b1;
          rd_addr = cnt_q[IW-1:0];
        end
        // The entry read in the previous cycle is checked now.
        if (cnt_q != '0) begin
          if (valid_q[chk_idx]) begin
            if (rd_q.key == req_q.key) begin
              hit_d     = 1'b1;
              hit_idx_d = chk_idx;
              hit_ent_d = rd_q;
            end
            if (!vic_q || rd_q.count < vic_cnt_q ||
                (rd_q.count == vic_cnt_q && age > vic_age_q)) begin
              vic_d     = 1'b1;
              vic_idx_d = chk_idx;
              vic_key_d = rd_q.key;
              vic_cnt_d = rd_q.count;
              vic_age_d = age;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_idx;
          end
        end
        if (cnt_q == SW'(ENTRIES)) begin
          state_d = lfu_pkg::ST_WRITE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      lfu_pkg::ST_WRITE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d           = lfu_pkg::ST_IDLE;
          out_valid_d       = 1'b1;
          out_d.hit         = hit_q;
          out_d.read_value  = '0;
          out_d.evicted     = 1'b0;
          out_d.evicted_key = '0;
          if (req_q.func == lfu_pkg::FUNC_GET) begin
            if (hit_q) begin
              out_d.read_value = hit_ent_q.data;
              we           = 1'b1;
              wr_ent.count = bumped;
              wr_ent.stamp = clk_q;
              clk_d        = clk_q + 1'b1;
            end else begin
              out_d.read_value = lfu_pkg::READ_MISS;
            end
          end else if (cap_q != '0) begin
            if (hit_q) begin
              we           = 1'b1;
              wr_ent.data  = req_q.value;
              wr_ent.count = bumped;
              wr_ent.stamp = clk_q;
              clk_d        = clk_q + 1'b1;
            end else if (evict || free_q) begin
              // A victim frees its slot before the lowest free slot is picked.
              we           = 1'b1;
              wr_addr      = dst;
              wr_ent.key   = req_q.key;
              wr_ent.data  = req_q.value;
              wr_ent.count = lfu_pkg::CNT_W'(1);
              wr_ent.stamp = clk_q;
              clk_d        = clk_q + 1'b1;
              if (evict) begin
                out_d.evicted     = 1'b1;
                out_d.evicted_key = vic_key_q;
                valid_d[vic_idx_q] = 1'b0;
              end else begin
                filled_d = filled_q + 1'b1;
              end
              valid_d[dst] = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = lfu_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= FW'(ENTRIES))
    else $error("fill count exceeds entry count");

  a_filled_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(filled_q))
    else $error("fill count differs from number of valid entries");

  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.evicted |-> !out_data_o.hit && out_data_o.read_value == '0)
    else $error("eviction reported for a hit or a get");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lfu_pkg::ST_SCAN |-> !we)
    else $error("entry memory written during a scan");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lfu_pkg::ST_WRITE && state_d == lfu_pkg::ST_IDLE |=> out_valid_q)
    else $error("finished request produced no result");
`endif

endmodule
`default_nettype wire

// ===== test/lfu_cache_replacement_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache testbench
// Drives get and put requests through the LFU store under several capacity
// settings and random stalls, predicts each response and checks it.
// ----------------------------------------------------------------------------
module lfu_cache_replacement_tb;

  localparam int NSLOT = 16;
  localparam int WATCH_LIMIT = 20000;

  class lfu_scoreboard;
    logic        valid_q [NSLOT];
    logic [31:0] key_q [NSLOT];
    logic [31:0] data_q [NSLOT];
    logic [15:0] cnt_q [NSLOT];
    logic [31:0] stamp_q [NSLOT];
    logic [31:0] clock_q;
    int unsigned filled_q;
    int unsigned cap_q;
    lfu_pkg::rsp_t pending[$];
    int          errors;
    int          checked;

    function void clear();
      foreach (valid_q[i]) valid_q[i] = 1'b0;
      clock_q = '0;
      filled_q = 0;
      cap_q = 16;
      errors = 0;
      checked = 0;
    endfunction

    function void set_capacity(logic [4:0] c);
      cap_q = c;
    endfunction

    function int find_key(logic [31:0] k);
      for (int i = 0; i < NSLOT; i++)
        if (valid_q[i] && key_q[i] == k) return i;
      return -1;
    endfunction

    function void touch(int s, bit bump);
      if (bump && cnt_q[s] != lfu_pkg::COUNT_MAX) cnt_q[s] = cnt_q[s] + 1'b1;
      stamp_q[s] = clock_q;
      clock_q = clock_q + 1;
    endfunction

    // Works out the response of one accepted request and updates the store.
    function void note_request(lfu_pkg::req_t r);
      lfu_pkg::rsp_t exp;
      int          s;
      int          best;
      int unsigned cap;
      logic [31:0] age;
      logic [31:0] best_age;
      exp = '0;
      cap = (cap_q > NSLOT) ? NSLOT : cap_q;
      s = find_key(r.key);
      exp.hit = (s >= 0);
      if (r.func == lfu_pkg::FUNC_GET) begin
        if (s >= 0) begin
          exp.read_value = data_q[s];
          touch(s, 1'b1);
        end else begin
          exp.read_value = lfu_pkg::READ_MISS;
        end
      end else if (cap != 0) begin
        if (s >= 0) begin
          data_q[s] = r.value;
          touch(s, 1'b1);
        end else begin
          if (filled_q >= cap) begin
            best = -1;
            best_age = '0;
            for (int i = 0; i < NSLOT; i++) begin
              if (!valid_q[i]) continue;
              age = clock_q - stamp_q[i];
              if (best < 0 || cnt_q[i] < cnt_q[best] ||
                  (cnt_q[i] == cnt_q[best] && age > best_age)) begin
                best = i;
                best_age = age;
              end
            end
            if (best >= 0) begin
              exp.evicted = 1'b1;
              exp.evicted_key = key_q[best];
              valid_q[best] = 1'b0;
              filled_q--;
            end
          end
          for (int i = 0; i < NSLOT; i++) begin
            if (!valid_q[i]) begin
              valid_q[i] = 1'b1;
              key_q[i] = r.key;
              data_q[i] = r.value;
              cnt_q[i] = 16'd1;
              touch(i, 1'b0);
              filled_q++;
              break;
            end
          end
        end
      end
      pending.push_back(exp);
    endfunction

    function void check_response(lfu_pkg::rsp_t got);
      lfu_pkg::rsp_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.hit !== exp.hit)
        $display("%0t: hit exp %b got %b", $time, exp.hit, got.hit);
      if (got.read_value !== exp.read_value)
        $display("%0t: read_value exp %h got %h", $time, exp.read_value, got.read_value);
      if (got.evicted !== exp.evicted)
        $display("%0t: evicted exp %b got %b", $time, exp.evicted, got.evicted);
      if (got.evicted_key !== exp.evicted_key)
        $display("%0t: evicted_key exp %h got %h", $time, exp.evicted_key, got.evicted_key);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  lfu_pkg::req_t in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  lfu_pkg::rsp_t out_data_o;

  lfu_scoreboard lfu_sb;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_off = 0;
  int  quiet_cycles = 0;
  logic [31:0] key_pool [8];

  lfu_cache_replacement #(.ENTRIES(NSLOT)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Response side: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) lfu_sb.check_response(out_data_o);
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCH_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Valid stays high from one request to the next unless the sender idles;
  // drain() drops it once a stream of requests ends.
  task automatic send_request(logic f, logic [31:0] k, logic [31:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{func: f, key: k, value: v};
    do @(posedge clk_i); while (!in_ready_o);
    lfu_sb.note_request(in_data_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (lfu_sb.pending.size() != 0) @(posedge clk_i);
    repeat (NSLOT + 8) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [4:0] c);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    lfu_sb.set_capacity(c);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly keys from a small pool so hits, updates and evictions are common.
  task automatic random_phase(int n);
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)]
                                   : (($urandom_range(3) == 0) ? $urandom_range(40) : $urandom);
      send_request(1'($urandom_range(1)), k, $urandom);
    end
  endtask

  initial begin
    lfu_sb = new();
    lfu_sb.clear();
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom_range(20);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes of key and value, misses, hits, evictions.
    send_request(lfu_pkg::FUNC_GET, 32'h8000_0000, 32'h0);
    send_request(lfu_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(lfu_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(lfu_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lfu_pkg::FUNC_PUT, 32'h0, 32'h0);
    send_request(lfu_pkg::FUNC_GET, 32'h8000_0000, 32'h1234);
    send_request(lfu_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(lfu_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h5555_AAAA);
    write_capacity(5'd2);
    // The store holds four entries, two above capacity; each miss evicts.
    send_request(lfu_pkg::FUNC_PUT, 32'd100, 32'd1);
    send_request(lfu_pkg::FUNC_PUT, 32'd101, 32'd2);
    send_request(lfu_pkg::FUNC_GET, 32'd101, 32'd0);
    send_request(lfu_pkg::FUNC_PUT, 32'd102, 32'd3);
    write_capacity(5'd0);
    // Capacity zero: puts change nothing, gets still see old entries.
    send_request(lfu_pkg::FUNC_PUT, 32'd101, 32'd9);
    send_request(lfu_pkg::FUNC_PUT, 32'd200, 32'd9);
    send_request(lfu_pkg::FUNC_GET, 32'd101, 32'd0);
    send_request(lfu_pkg::FUNC_GET, 32'd200, 32'd0);
    write_capacity(5'd31);
    for (int i = 0; i < 18; i++) send_request(lfu_pkg::FUNC_PUT, i + 300, i);

    // Hold the output off long enough that the block stalls its input.
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        random_phase(6);
        drain();
      end
    join

    send_idle_pct = 20; recv_idle_pct = 61;
    random_phase(350);
    write_capacity(5'd1);
    random_phase(100);
    send_idle_pct = 61; recv_idle_pct = 20;
    write_capacity(5'd16);
    random_phase(350);
    write_capacity(5'd5);
    random_phase(100);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_capacity(5'd17);
    random_phase(350);
    write_capacity(5'd0);
    random_phase(20);
    write_capacity(5'd8);
    random_phase(60);
    drain();

    $display("Checked %0d responses over capacities 0, 1, 2, 5, 8, 16, 17 and 31,",
             lfu_sb.checked);
    $display("with hits, misses, evictions and input and output stalls.");
    if (lfu_sb.errors == 0 && lfu_sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/lfu_pkg.sv
sv/lfu_cache_replacement.sv
test/lfu_cache_replacement_tb.sv
